FILE: rtl/three_wire_serial_master_macros.svh
// Assertion helpers shared by the three-wire serial master RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef THREE_WIRE_SERIAL_MASTER_MACROS_SVH
`define THREE_WIRE_SERIAL_MASTER_MACROS_SVH

// Same-cycle implication
`define CWSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication
`define CWSM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/cwsm_pkg.sv
`default_nettype none

package cwsm_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETUP_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TICKS = 2'd2;

  // Configuration reset values
  localparam logic [7:0] PHASE_TICKS_RST  = 8'd4;
  localparam logic [7:0] SETUP_TICKS_RST  = 8'd3;
  localparam logic [7:0] SAMPLE_TICKS_RST = 8'd14;

  // Bits shifted out, and read bits shifted in, per access kind
  localparam logic [4:0] RD_OUT_BITS = 5'd8;
  localparam logic [4:0] WR_OUT_BITS = 5'd16;
  localparam logic [4:0] RD_IN_BITS  = 5'd8;

  // Request codes
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef struct packed {
    logic [7:0] phase_ticks;
    logic [7:0] ce_setup_ticks;
    logic [7:0] sample_wait_ticks;
  } cwsm_cfg_t;

  typedef struct packed {
    logic       req_type;
    logic       is_read;
    logic [7:0] address;
    logic [7:0] write_data;
    logic       data_pin_in;
  } cwsm_item_t;

  typedef struct packed {
    logic       ce_pin;
    logic       sclk_pin;
    logic       data_pin_out;
    logic       data_drive_en;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
  } cwsm_res_t;

endpackage

`default_nettype wire

FILE: rtl/cwsm_cfg.sv
`default_nettype none

module cwsm_cfg
  import cwsm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output cwsm_cfg_t                 cfg
);

  cwsm_cfg_t cfg_r;

  // Writes never stall
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode index and update one register; unknown indexes drop the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks       <= PHASE_TICKS_RST;
      cfg_r.ce_setup_ticks    <= SETUP_TICKS_RST;
      cfg_r.sample_wait_ticks <= SAMPLE_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PHASE_TICKS:  cfg_r.phase_ticks       <= cfg_data;
        CFG_SETUP_TICKS:  cfg_r.ce_setup_ticks    <= cfg_data;
        CFG_SAMPLE_TICKS: cfg_r.sample_wait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cwsm_step.sv
`default_nettype none

`include "three_wire_serial_master_macros.svh"

module cwsm_step
  import cwsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_valid,
  input  wire cwsm_item_t item,
  input  wire cwsm_cfg_t  cfg,
  output cwsm_res_t       res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETUP,
    PH_SH_LOW,
    PH_SH_HIGH,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_RD_WAIT,
    PH_HOLD
  } phase_t;

  phase_t      phase_r,     phase_nxt;
  logic [4:0]  bit_count_r, bit_count_nxt;
  logic [15:0] out_shift_r, out_shift_nxt;
  logic [7:0]  in_shift_r,  in_shift_nxt;
  logic [7:0]  tick_r,      tick_nxt;
  logic        read_mode_r, read_mode_nxt;
  logic        sclk_r,      sclk_nxt;

  logic        expired;
  logic [4:0]  bc_dec;
  logic        done_read;
  logic        releasing;
  logic        ce;

  assign expired = (tick_r <= 8'd1);
  assign bc_dec  = (bit_count_r != 5'd0) ? (bit_count_r - 5'd1) : bit_count_r;

  // Next state for one word: start a new access or advance time by one tick
  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    out_shift_nxt = out_shift_r;
    in_shift_nxt  = in_shift_r;
    tick_nxt      = tick_r;
    read_mode_nxt = read_mode_r;
    sclk_nxt      = sclk_r;
    done_read     = 1'b0;
    if (step_valid) begin
      if (item.req_type == REQ_START) begin
        // start while busy is dropped
        if (phase_r == PH_IDLE) begin
          read_mode_nxt = item.is_read;
          if (item.is_read) begin
            out_shift_nxt = {8'h00, item.address};
            bit_count_nxt = RD_OUT_BITS;
          end else begin
            out_shift_nxt = {item.write_data, item.address};
            bit_count_nxt = WR_OUT_BITS;
          end
          sclk_nxt  = 1'b0;
          phase_nxt = PH_SETUP;
          tick_nxt  = cfg.ce_setup_ticks;
        end
      end else if (phase_r != PH_IDLE) begin
        if (!expired) begin
          tick_nxt = tick_r - 8'd1;
        end else begin
          unique case (phase_r)
            PH_SETUP: begin
              phase_nxt = PH_SH_LOW;
              tick_nxt  = cfg.phase_ticks;
            end
            PH_SH_LOW: begin
              sclk_nxt  = 1'b1;
              phase_nxt = PH_SH_HIGH;
              tick_nxt  = cfg.phase_ticks;
            end
            PH_SH_HIGH: begin
              out_shift_nxt = {1'b0, out_shift_r[15:1]};
              bit_count_nxt = bc_dec;
              if (bc_dec != 5'd0) begin
                sclk_nxt  = 1'b0;
                phase_nxt = PH_SH_LOW;
                tick_nxt  = cfg.phase_ticks;
              end else if (read_mode_r) begin
                // keep SCLK high one more phase, then start reading
                bit_count_nxt = RD_IN_BITS;
                phase_nxt     = PH_RD_HIGH;
                tick_nxt      = cfg.phase_ticks;
              end else begin
                sclk_nxt  = 1'b0;
                phase_nxt = PH_HOLD;
                tick_nxt  = cfg.ce_setup_ticks;
              end
            end
            PH_RD_LOW: begin
              sclk_nxt  = 1'b1;
              phase_nxt = PH_RD_HIGH;
              tick_nxt  = cfg.phase_ticks;
            end
            PH_RD_HIGH: begin
              sclk_nxt  = 1'b0;
              phase_nxt = PH_RD_WAIT;
              tick_nxt  = cfg.sample_wait_ticks;
            end
            PH_RD_WAIT: begin
              // sample into bit 7, shift right
              in_shift_nxt  = {item.data_pin_in, in_shift_r[7:1]};
              bit_count_nxt = bc_dec;
              if (bc_dec != 5'd0) begin
                phase_nxt = PH_RD_LOW;
                tick_nxt  = cfg.phase_ticks;
              end else begin
                phase_nxt = PH_HOLD;
                tick_nxt  = cfg.ce_setup_ticks;
              end
            end
            PH_HOLD: begin
              sclk_nxt  = 1'b0;
              phase_nxt = PH_IDLE;
              tick_nxt  = 8'd0;
              done_read = read_mode_r;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Pin levels after this word
  assign releasing = (phase_nxt == PH_RD_LOW) || (phase_nxt == PH_RD_HIGH) ||
                     (phase_nxt == PH_RD_WAIT) ||
                     ((phase_nxt == PH_HOLD) && read_mode_nxt);
  assign ce        = (phase_nxt != PH_IDLE);

  always_comb begin
    res.ce_pin        = ce;
    res.sclk_pin      = sclk_nxt;
    res.data_drive_en = !releasing;
    res.data_pin_out  = (!releasing && ce) ? out_shift_nxt[0] : 1'b0;
    res.busy_res      = ce;
    res.read_valid    = done_read;
    res.read_data     = in_shift_nxt;
  end

  // Hold link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_count_r <= 5'd0;
      out_shift_r <= 16'h0000;
      in_shift_r  <= 8'h00;
      tick_r      <= 8'd0;
      read_mode_r <= 1'b0;
      sclk_r      <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      out_shift_r <= out_shift_nxt;
      in_shift_r  <= in_shift_nxt;
      tick_r      <= tick_nxt;
      read_mode_r <= read_mode_nxt;
      sclk_r      <= sclk_nxt;
    end
  end

  `CWSM_ASSERT_NXT(a_start_idle, step_valid && item.req_type && phase_r == PH_IDLE, phase_r == PH_SETUP && !sclk_r)
  `CWSM_ASSERT_NXT(a_start_busy, step_valid && item.req_type && phase_r != PH_IDLE, $stable(phase_r) && $stable(tick_r) && $stable(bit_count_r))
  `CWSM_ASSERT_IMP(a_bit_range, phase_r != PH_IDLE, bit_count_r <= WR_OUT_BITS)

endmodule

`default_nettype wire

FILE: rtl/cwsm_oreg.sv
`default_nettype none

module cwsm_oreg
  import cwsm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire cwsm_res_t res,
  output logic           out_valid,
  input  wire logic      out_ready,
  output cwsm_res_t      out_res
);

  logic      out_valid_r;
  cwsm_res_t res_r;

  // Take a new word whenever the result slot is empty or being drained
  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/three_wire_serial_master.sv
// Channel  | Direction | Handshake            | Payload
// in_      | input     | in_valid / in_ready  | req_type, is_read, address, write_data, data_pin_in
// out_     | output    | out_valid/out_ready  | ce_pin, sclk_pin, data_pin_out, data_drive_en,
//          |           |                      | busy_res, read_valid, read_data
// cfg_     | input     | cfg_valid/cfg_ready  | cfg_index (0..2), cfg_data
//
// One word in, one word out; a word is taken every cycle unless a result waits unaccepted,
// and its result is formed combinationally and shown from the result register in the next cycle.
// in_ready drops only while a result waits and out_ready is low.
// cfg_ready is always high; writes take effect on the next cycle.
// Reset (rst_n low, synchronous) returns the link to idle and the
// registers to 4, 3 and 14 ticks.
`default_nettype none

`include "three_wire_serial_master_macros.svh"

module three_wire_serial_master
  import cwsm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_req_type,
  input  wire logic                 in_is_read,
  input  wire logic [7:0]           in_address,
  input  wire logic [7:0]           in_write_data,
  input  wire logic                 in_data_pin_in,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_ce_pin,
  output logic                      out_sclk_pin,
  output logic                      out_data_pin_out,
  output logic                      out_data_drive_en,
  output logic                      out_busy_res,
  output logic                      out_read_valid,
  output logic [7:0]                out_read_data,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  cwsm_cfg_t  cfg;
  cwsm_item_t item;
  cwsm_res_t  res;
  cwsm_res_t  out_res;
  logic       accept;

  assign item.req_type    = in_req_type;
  assign item.is_read     = in_is_read;
  assign item.address     = in_address;
  assign item.write_data  = in_write_data;
  assign item.data_pin_in = in_data_pin_in;

  assign accept = in_valid && in_ready;

  cwsm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cwsm_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (accept),
    .item       (item),
    .cfg        (cfg),
    .res        (res)
  );

  cwsm_oreg u_oreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Fan the result word out to ports
  assign out_ce_pin        = out_res.ce_pin;
  assign out_sclk_pin      = out_res.sclk_pin;
  assign out_data_pin_out  = out_res.data_pin_out;
  assign out_data_drive_en = out_res.data_drive_en;
  assign out_busy_res      = out_res.busy_res;
  assign out_read_valid    = out_res.read_valid;
  assign out_read_data     = out_res.read_data;

  `CWSM_ASSERT_NXT(a_accept_gives_out, accept, out_valid)
  `CWSM_ASSERT_IMP(a_read_done_idle, out_valid && out_read_valid, !out_busy_res && !out_ce_pin)

endmodule

`default_nettype wire
